[rtl/core/lcfs_pkg.sv]
`default_nettype none
package lcfs_pkg;

  localparam int TIME_BITS  = 32;
  localparam int RATIO_BITS = 16;
  // The integer part of the long division covers a 33-bit non-negative time offset.
  localparam int INT_STEPS  = 33;
  localparam int DIV_STEPS  = INT_STEPS + RATIO_BITS;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic signed [31:0] play_time;
    logic [30:0]        seg_start;
    logic [30:0]        fixed_len;
    logic [30:0]        preutter_len;
    logic [30:0]        total_len;
    logic [15:0]        source_id;
    logic [15:0]        gain_in;
    logic               list_end;
  } item_t;

  // One finished segment, ready to be turned into one or two frames.
  typedef struct packed {
    logic        is_loop;
    logic [31:0] pos_a;
    logic [31:0] pos_b;
    logic [15:0] src;
    logic [15:0] gain;
    logic [15:0] gcnt;
    logic        lend;
  } ent_t;

  // Contents of one divider pipeline stage.
  typedef struct packed {
    logic                 vld;
    logic                 is_loop;
    logic signed [32:0]   pos_fix;
    logic [31:0]          fea;
    logic [31:0]          fel;
    logic [30:0]          div;
    logic                 div_ok;
    logic [30:0]          r;
    logic [DIV_STEPS-1:0] q;
    logic [30:0]          rem;
    logic [15:0]          src;
    logic [15:0]          gain;
    logic                 lend;
  } stg_t;

  localparam longint SAT_HI = (64'sd1 <<< (TIME_BITS - 1)) - 64'sd1;
  localparam longint SAT_LO = -SAT_HI - 64'sd1;

  function automatic logic [31:0] sat_pos(input logic signed [33:0] v);
    longint w;
    w = longint'(v);
    if (w > SAT_HI) w = SAT_HI;
    if (w < SAT_LO) w = SAT_LO;
    return w[31:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/lcfs_front.sv]
`default_nettype none
module lcfs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_vld,
  input  wire lcfs_pkg::item_t item,
  output logic               push,
  output lcfs_pkg::ent_t     ent
);
  import lcfs_pkg::*;

  stg_t pipe [0:DIV_STEPS];
  stg_t cls;
  logic fin_vld;

  // Classification: the sign of the time past the fixed end picks the region.
  always_comb begin
    logic signed [33:0] fer;
    logic signed [33:0] past;
    logic signed [31:0] loop_len;
    fer      = $signed({3'b0, item.fixed_len}) - $signed({3'b0, item.preutter_len});
    past     = $signed({{2{item.play_time[31]}}, item.play_time}) - fer;
    loop_len = $signed({1'b0, item.total_len}) - $signed({1'b0, item.fixed_len});
    cls         = '0;
    cls.vld     = in_vld;
    cls.is_loop = !past[33];
    cls.pos_fix = $signed({2'b0, item.seg_start}) + $signed({item.play_time[31], item.play_time});
    cls.fea     = {1'b0, item.seg_start} + {1'b0, item.fixed_len};
    cls.fel     = {1'b0, item.seg_start} + {1'b0, item.total_len};
    cls.div     = loop_len[30:0];
    cls.div_ok  = !loop_len[31] && (loop_len != '0);
    cls.q       = {past[32:0], {RATIO_BITS{1'b0}}};
    cls.src     = item.source_id;
    cls.gain    = item.gain_in;
    cls.lend    = item.list_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].vld <= 1'b0;
    end else if (adv) begin
      pipe[0] <= cls;
    end
  end

  // One restoring division step per stage; the remainder is captured after
  // the integer steps, the fraction bits continue into the ratio.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    stg_t nx;
    always_comb begin
      logic [31:0] r2;
      logic [31:0] diff;
      logic        ge;
      r2   = {pipe[i].r, pipe[i].q[DIV_STEPS-1]};
      diff = r2 - {1'b0, pipe[i].div};
      ge   = r2 >= {1'b0, pipe[i].div};
      nx   = pipe[i];
      nx.r = ge ? diff[30:0] : r2[30:0];
      nx.q = {pipe[i].q[DIV_STEPS-2:0], ge};
      if (i == INT_STEPS - 1) nx.rem = nx.r;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[i+1].vld <= 1'b0;
      end else if (adv) begin
        pipe[i+1] <= nx;
      end
    end
  end

  // Final stage: gain split and saturated positions.
  always_ff @(posedge clk) begin
    logic [30:0]              rem;
    logic [RATIO_BITS-1:0]    ratio;
    logic [16+RATIO_BITS-1:0] prod;
    stg_t                     s;
    s     = pipe[DIV_STEPS];
    rem   = s.div_ok ? s.rem : '0;
    ratio = s.div_ok ? s.q[RATIO_BITS-1:0] : '0;
    prod  = s.gain * ratio;
    if (rst) begin
      fin_vld <= 1'b0;
    end else if (adv) begin
      fin_vld     <= s.vld;
      ent.is_loop <= s.is_loop;
      ent.src     <= s.src;
      ent.gain    <= s.gain;
      ent.lend    <= s.lend;
      if (s.is_loop) begin
        ent.pos_a <= sat_pos($signed({2'b0, s.fea} + {3'b0, rem}));
        ent.pos_b <= sat_pos($signed({2'b0, s.fel} - {3'b0, rem}));
        ent.gcnt  <= prod[16+RATIO_BITS-1:RATIO_BITS];
      end else begin
        ent.pos_a <= sat_pos({s.pos_fix[32], s.pos_fix});
        ent.pos_b <= '0;
        ent.gcnt  <= '0;
      end
    end
  end

  assign push = adv && fin_vld;

endmodule
`default_nettype wire

[rtl/core/lcfs_fifo.sv]
`default_nettype none
module lcfs_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lcfs_pkg::ent_t wdata,
  input  wire logic          pop,
  output lcfs_pkg::ent_t     head,
  output logic               not_empty,
  output logic               full
);
  import lcfs_pkg::*;

  ent_t             mem [0:FIFO_DEPTH-1];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  assign head      = mem[rptr];
  assign not_empty = count != '0;
  assign full      = count == (PTR_W+1)'(FIFO_DEPTH);

endmodule
`default_nettype wire

[rtl/core/lcfs_back.sv]
`default_nettype none
module lcfs_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lcfs_pkg::ent_t head,
  input  wire logic          not_empty,
  output logic               pop,
  output logic               strobe,
  output logic signed [31:0] frame_pos,
  output logic [15:0]        frame_source,
  output logic [15:0]        frame_gain,
  output logic               run_last,
  output logic               list_last
);
  import lcfs_pkg::*;

  // High while the mirrored frame of a loop segment is still owed.
  logic second;

  assign pop = not_empty && (second || !head.is_loop);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      second <= 1'b0;
    end else begin
      strobe <= not_empty;
      if (not_empty) second <= head.is_loop && !second;
    end
  end

  always_ff @(posedge clk) begin
    frame_source <= head.src;
    if (second) begin
      frame_pos  <= head.pos_b;
      frame_gain <= head.gcnt;
      run_last   <= 1'b1;
      list_last  <= head.lend;
    end else begin
      frame_pos  <= head.pos_a;
      frame_gain <= head.gain - head.gcnt;
      run_last   <= !head.is_loop;
      list_last  <= !head.is_loop && head.lend;
    end
  end

endmodule
`default_nettype wire

[rtl/core/loop_crossfade_frame_select_top.sv]
`default_nettype none
// Loop cross-fade frame selector.
// Command channel: a segment word (play_time, seg_start, fixed_len, preutter_len,
// total_len, source_id, gain_in, list_end) is taken at a rising edge where start
// is high and busy is low. Result channel: each frame word appears on frame_pos,
// frame_source, frame_gain, run_last and list_last for exactly one cycle while
// strobe is high; the receiver cannot hold it off.
// A segment before its fixed end gives one frame; a segment in the loop region
// gives a forward frame and then, in the very next cycle, the mirrored frame.
// From acceptance to the first frame a word passes one classification stage,
// 49 long-division steps of the loop remainder and cross-fade ratio (one step
// per stage), one gain and position stage, the queue and the output register.
// The divider pipeline takes a word every cycle while the queue is not full;
// the output register emits one frame per cycle, so loop segments sustain one
// word per two frames and fixed-region segments one per cycle.
// A four-entry queue sits between the divider and the frame emitter. When it
// fills, the whole divider pipeline holds and busy is raised until a slot frees.
// Synchronous reset empties the pipeline and the queue and drops strobe.
module loop_crossfade_frame_select_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] play_time,
  input  wire logic [30:0]        seg_start,
  input  wire logic [30:0]        fixed_len,
  input  wire logic [30:0]        preutter_len,
  input  wire logic [30:0]        total_len,
  input  wire logic [15:0]        source_id,
  input  wire logic [15:0]        gain_in,
  input  wire logic               list_end,
  output logic                    strobe,
  output logic signed [31:0]      frame_pos,
  output logic [15:0]             frame_source,
  output logic [15:0]             frame_gain,
  output logic                    run_last,
  output logic                    list_last
);
  import lcfs_pkg::*;

  item_t item;
  ent_t  ent;
  ent_t  head;
  logic  push;
  logic  pop;
  logic  not_empty;
  logic  full;
  logic  adv;

  assign item = '{play_time, seg_start, fixed_len, preutter_len, total_len,
                  source_id, gain_in, list_end};

  // The pipeline moves only while the queue can take whatever leaves it.
  assign adv  = !full;
  assign busy = full;

  lcfs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .in_vld (start && !busy),
    .item   (item),
    .push   (push),
    .ent    (ent)
  );

  lcfs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (ent),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  lcfs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .not_empty    (not_empty),
    .pop          (pop),
    .strobe       (strobe),
    .frame_pos    (frame_pos),
    .frame_source (frame_source),
    .frame_gain   (frame_gain),
    .run_last     (run_last),
    .list_last    (list_last)
  );

endmodule
`default_nettype wire

[rtl/core/lcfs_checker.sv]
`default_nettype none
module lcfs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        strobe,
  input wire logic [15:0] frame_source,
  input wire logic        run_last,
  input wire logic        list_last
);

  // Reset leaves no frame on the output.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("frame strobe right after reset");

  // A forward loop frame is followed at once by its mirrored frame.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    strobe && !run_last |=> strobe && run_last)
    else $error("mirrored frame did not follow");

  a_pair_src: assert property (@(posedge clk) disable iff (rst)
    strobe && !run_last |=> frame_source == $past(frame_source))
    else $error("mirrored frame changed source");

  a_list_last: assert property (@(posedge clk) disable iff (rst)
    strobe && list_last |-> run_last)
    else $error("list end flagged on a non-final frame");

endmodule

bind loop_crossfade_frame_select_top lcfs_checker u_lcfs_checker (
  .clk          (clk),
  .rst          (rst),
  .strobe       (strobe),
  .frame_source (frame_source),
  .run_last     (run_last),
  .list_last    (list_last)
);
`default_nettype wire

[tb/sv/loop_crossfade_frame_select_top_tb.sv]
`default_nettype none
module loop_crossfade_frame_select_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcfs_pkg::*;

  // One expected or observed frame word.
  typedef struct {
    logic [31:0] pos;
    logic [15:0] src;
    logic [15:0] gain;
    logic        rlast;
    logic        llast;
  } frame_t;

  // Keeps the frames that accepted segment words must produce, in order, and
  // compares each emitted frame with the oldest one.
  class frame_scoreboard;
    frame_t pending[$];
    int     mismatches;
    int     checked;
    int     segments;
    int     loop_segments;

    function automatic logic [31:0] clamp_pos(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (TIME_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[31:0];
    endfunction

    function automatic void note_segment(item_t it);
      longint t;
      longint st;
      longint fx;
      longint fe_rel;
      longint lp;
      longint fe_abs;
      longint rem;
      longint ratio;
      longint g;
      longint g_cnt;
      frame_t f;
      t = longint'(it.play_time);
      st = longint'({1'b0, it.seg_start});
      fx = longint'({1'b0, it.fixed_len});
      fe_rel = fx - longint'({1'b0, it.preutter_len});
      g = longint'({1'b0, it.gain_in});
      segments++;
      f.src = it.source_id;
      if (t < fe_rel) begin
        f.pos = clamp_pos(st + t);
        f.gain = it.gain_in;
        f.rlast = 1'b1;
        f.llast = it.list_end;
        pending.push_back(f);
        return;
      end
      loop_segments++;
      lp = longint'({1'b0, it.total_len}) - fx;
      fe_abs = st + fx;
      rem = 0;
      ratio = 0;
      if (lp > 0) begin
        rem = (t - fe_rel) % lp;
        ratio = (rem <<< RATIO_BITS) / lp;
      end
      g_cnt = (g * ratio) >>> RATIO_BITS;
      f.pos = clamp_pos(fe_abs + rem);
      f.gain = 16'(g - g_cnt);
      f.rlast = 1'b0;
      f.llast = 1'b0;
      pending.push_back(f);
      f.pos = clamp_pos(fe_abs + lp - rem);
      f.gain = 16'(g_cnt);
      f.rlast = 1'b1;
      f.llast = it.list_end;
      pending.push_back(f);
    endfunction

    function automatic void check_frame(frame_t got);
      frame_t exp_f;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected frame pos=%0d src=%0d gain=%0d",
                   $signed(got.pos), got.src, got.gain);
        return;
      end
      exp_f = pending.pop_front();
      if (got.pos !== exp_f.pos || got.src !== exp_f.src || got.gain !== exp_f.gain ||
          got.rlast !== exp_f.rlast || got.llast !== exp_f.llast) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: frame exp pos=%0d src=%0d gain=%0d rl=%0b ll=%0b, ",
                    "got pos=%0d src=%0d gain=%0d rl=%0b ll=%0b"},
                   $signed(exp_f.pos), exp_f.src, exp_f.gain, exp_f.rlast, exp_f.llast,
                   $signed(got.pos), got.src, got.gain, got.rlast, got.llast);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] play_time = '0;
  logic [30:0]        seg_start = '0;
  logic [30:0]        fixed_len = '0;
  logic [30:0]        preutter_len = '0;
  logic [30:0]        total_len = '0;
  logic [15:0]        source_id = '0;
  logic [15:0]        gain_in = '0;
  logic               list_end = 1'b0;
  logic               strobe;
  logic signed [31:0] frame_pos;
  logic [15:0]        frame_source;
  logic [15:0]        frame_gain;
  logic               run_last;
  logic               list_last;

  loop_crossfade_frame_select_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .play_time(play_time), .seg_start(seg_start), .fixed_len(fixed_len),
    .preutter_len(preutter_len), .total_len(total_len), .source_id(source_id),
    .gain_in(gain_in), .list_end(list_end), .strobe(strobe), .frame_pos(frame_pos),
    .frame_source(frame_source), .frame_gain(frame_gain), .run_last(run_last),
    .list_last(list_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_scoreboard sb = new();
  // The limit covers 2019 words at the slowest rate with a full idle gap each,
  // plus the pipeline latency, many times over.
  localparam int CYCLE_LIMIT = 400000;
  int  cycles = 0;
  bit  quiet_stretch = 1'b0;

  // Frames are sampled at the rising edge that ends their strobe cycle.
  always @(posedge clk) begin
    frame_t f;
    cycles <= cycles + 1;
    if (!rst && strobe) begin
      f.pos = frame_pos;
      f.src = frame_source;
      f.gain = frame_gain;
      f.rlast = run_last;
      f.llast = list_last;
      sb.check_frame(f);
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d frames outstanding",
               cycles, sb.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drives one segment word from a falling edge and holds it until the block
  // takes it. Random idle cycles come first unless a quiet stretch is on;
  // start drops only for those idle cycles.
  task automatic send_segment(item_t it);
    bit taken;
    if (!quiet_stretch) begin
      while ($urandom_range(99) < 30) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    play_time <= it.play_time;
    seg_start <= it.seg_start;
    fixed_len <= it.fixed_len;
    preutter_len <= it.preutter_len;
    total_len <= it.total_len;
    source_id <= it.source_id;
    gain_in <= it.gain_in;
    list_end <= it.list_end;
    start <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
    sb.note_segment(it);
  endtask

  function automatic logic [30:0] rand_len();
    case ($urandom_range(5))
      0: return 31'($urandom_range(15));
      1: return 31'($urandom_range(4000));
      2: return 31'($urandom) | 31'h7FFF_0000;
      default: return 31'($urandom_range(1000000));
    endcase
  endfunction

  // Most random words are well-formed segments whose time lands in the fixed
  // part or a few loop lengths past it; the rest are raw field values.
  function automatic item_t random_segment();
    item_t it;
    longint fe_rel;
    longint lp;
    longint t;
    it.seg_start = rand_len();
    it.source_id = 16'($urandom);
    it.gain_in = ($urandom_range(3) == 0) ? 16'($urandom_range(4096)) : 16'($urandom);
    it.list_end = 1'($urandom_range(1));
    if ($urandom_range(9) < 2) begin
      it.play_time = $urandom;
      it.fixed_len = 31'($urandom);
      it.preutter_len = 31'($urandom);
      it.total_len = 31'($urandom);
      return it;
    end
    it.fixed_len = rand_len();
    it.preutter_len = ($urandom_range(3) == 0) ? rand_len() : 31'($urandom_range(2000));
    if ($urandom_range(9) == 0) it.total_len = 31'($urandom_range(it.fixed_len));
    else it.total_len = 31'(longint'(it.fixed_len) +
                            longint'($urandom_range(50000)) + 1 > 64'h7FFF_FFFF ?
                            31'h7FFF_FFFF : it.fixed_len + 31'($urandom_range(50000)) + 1);
    fe_rel = longint'({1'b0, it.fixed_len}) - longint'({1'b0, it.preutter_len});
    lp = longint'({1'b0, it.total_len}) - longint'({1'b0, it.fixed_len});
    if (lp < 1) lp = 1;
    if ($urandom_range(2) == 0) t = fe_rel - 1 - longint'($urandom_range(100000));
    else t = fe_rel + longint'($urandom_range(7)) * lp + longint'($urandom_range(int'(lp)));
    if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
    if (t < -64'sh8000_0000) t = -64'sh8000_0000;
    it.play_time = t[31:0];
    return it;
  endfunction

  function automatic item_t mk(longint t, longint st, longint fx, longint pr, longint tot,
                               int g, bit le);
    item_t it;
    it.play_time = t[31:0];
    it.seg_start = st[30:0];
    it.fixed_len = fx[30:0];
    it.preutter_len = pr[30:0];
    it.total_len = tot[30:0];
    it.source_id = 16'($urandom);
    it.gain_in = g[15:0];
    it.list_end = le;
    return it;
  endfunction

  localparam longint MAX31 = 64'h7FFF_FFFF;
  localparam longint MIN32 = -64'sh8000_0000;
  localparam longint MAX32 = 64'sh7FFF_FFFF;

  initial begin
    item_t it;
    int    w;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: fixed region, loop region, empty and negative loops,
    // negative fixed end, saturation at both ends, extreme gains and ids.
    send_segment(mk(10, 1000, 500, 20, 900, 4096, 1'b0));
    send_segment(mk(600, 1000, 500, 20, 900, 4096, 1'b1));
    send_segment(mk(480, 1000, 500, 20, 900, 65535, 1'b0));
    send_segment(mk(479, 0, 500, 20, 900, 65535, 1'b1));
    send_segment(mk(1000, 50, 500, 0, 500, 4096, 1'b1));
    send_segment(mk(1000, 50, 500, 0, 100, 4096, 1'b0));
    send_segment(mk(0, 0, 0, MAX31, 0, 1234, 1'b1));
    send_segment(mk(MIN32, 0, 0, 0, 0, 0, 1'b0));
    send_segment(mk(MIN32, MAX31, MAX31, 0, MAX31, 65535, 1'b1));
    send_segment(mk(MAX32, MAX31, 0, MAX31, MAX31, 65535, 1'b1));
    send_segment(mk(MAX32, MAX31, MAX31, MAX31, MAX31, 65535, 1'b0));
    send_segment(mk(MAX32, 0, 0, 0, 1, 4096, 1'b1));
    send_segment(mk(MAX32, 0, 0, 0, 3, 65535, 1'b0));
    send_segment(mk(MIN32, 0, 0, MAX31, MAX31, 65535, 1'b1));
    send_segment(mk(-5, MAX31, MAX31, MAX31, 0, 4096, 1'b0));
    send_segment(mk(MAX32, MAX31, 0, 0, 0, 0, 1'b1));
    send_segment(mk(MAX32, MAX31, 1, 0, MAX31, 65535, 1'b1));
    it = mk(-1, MAX31, MAX31, MAX31, MAX31, 65535, 1'b1);
    it.source_id = 16'hFFFF;
    send_segment(it);
    it.source_id = 16'h0000;
    it.play_time = 0;
    send_segment(it);

    // Random words; a stretch in the middle runs without idle gaps.
    for (w = 0; w < 2000; w++) begin
      quiet_stretch = (w >= 800 && w < 1100);
      send_segment(random_segment());
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Sent %0d segment words (%0d in a loop region), checked %0d frames.",
             sb.segments, sb.loop_segments, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
